@@ hw/rtl/sdr_pkg.sv @@
// Shared types and constants for the register-mapped signed divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdr_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 7;

  localparam logic [2:0] SelCtrl = 3'd0;
  localparam logic [2:0] SelNum  = 3'd1;
  localparam logic [2:0] SelDen  = 3'd2;
  localparam logic [2:0] SelQuo  = 3'd3;
  localparam logic [2:0] SelRem  = 3'd4;

  localparam logic [1:0] Mode3232 = 2'd0;
  localparam logic [1:0] Mode6432 = 2'd1;
  localparam logic [1:0] Mode6464 = 2'd2;

  localparam logic [63:0] NegZeroDiv32 = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] Low32Mask    = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] AllOnes      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [1:0]  ModeBits     = 2'd3;
  localparam int unsigned ErrBitPos    = 14;

  typedef struct packed {
    logic load;   // latch request, update regs, set up operands
    logic step;   // one restoring iteration
    logic finish; // sign fix-up and result write
  } sdr_cmd_t;

  typedef struct packed {
    logic last_step;
  } sdr_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/signed_divider_registers_core.sv @@
// Top level of the register-mapped signed divider.
// Depends on sdr_pkg, sdr_ctrl, sdr_datapath.
//
// Usage: present a request on operation_i, register_select_i, write_value_i
// and write_mask_i with start high; it is taken at an edge where busy is
// low. Each request gives one result on read_data_o, marked by done_o for
// exactly one cycle; the receiver cannot stall it.
// A read completes with done_o in the cycle after acceptance; busy stays
// low, so reads may follow every cycle.
// A write updates the register, then the restoring divider runs one
// quotient bit per cycle in its Step state, then a sign fix-up in its Fix
// state; done_o is registered at the end of Fix with zero data, and busy
// is high until then. A single shared subtract-and-shift loop does the divide.
// Reset clears mode, flag and all data registers to zero; the block is
// ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module signed_divider_registers_core import sdr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  output logic                  done_o,
  input  wire logic             operation_i,
  input  wire logic [2:0]       register_select_i,
  input  wire logic [DataW-1:0] write_value_i,
  input  wire logic [DataW-1:0] write_mask_i,
  output logic [DataW-1:0]      read_data_o
);
  sdr_cmd_t cmd;
  sdr_sts_t sts;

  sdr_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .operation_i, .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy), .done_o
  );

  sdr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .operation_i,
    .register_select_i, .write_value_i, .write_mask_i, .read_data_o
  );
endmodule
`default_nettype wire

@@ hw/rtl/sdr_datapath.sv @@
// Register file and radix-2 restoring divider datapath.
// Depends on sdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdr_datapath import sdr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sdr_cmd_t         cmd_i,
  output sdr_sts_t              sts_o,
  input  wire logic             operation_i,
  input  wire logic [2:0]       register_select_i,
  input  wire logic [DataW-1:0] write_value_i,
  input  wire logic [DataW-1:0] write_mask_i,
  output logic [DataW-1:0]      read_data_o
);
  logic [1:0]       mode_q, mode_d;
  logic             zflag_q;
  logic [DataW-1:0] num_q, num_d, den_q, den_d, quo_q, rem_q;
  logic [DataW-1:0] rd_q, rd_d;
  logic [DataW-1:0] dq_q, dr_q, dd_q;
  logic [CntW-1:0]  cnt_q;
  logic             nneg_q, qneg_q, spec_q;
  logic [DataW-1:0] sq_q, sr_q;
  logic [1:0]       m;

  logic [DataW-1:0] n_op, d_op, sq_d, sr_d;
  logic             spec_d, wide;
  logic [DataW:0]   trial;
  logic [DataW-1:0] rsh;

  always_comb begin
    m      = write_mask_i[1:0] & ModeBits;
    mode_d = mode_q;
    num_d  = num_q;
    den_d  = den_q;
    rd_d   = '0;
    if (operation_i) begin
      unique case (register_select_i)
        SelCtrl: mode_d = (write_value_i[1:0] & m) | (mode_q & ~m);
        SelNum:  num_d = (write_value_i & write_mask_i) | (num_q & ~write_mask_i);
        SelDen:  den_d = (write_value_i & write_mask_i) | (den_q & ~write_mask_i);
        default: ;
      endcase
    end else begin
      unique case (register_select_i)
        SelCtrl: rd_d = DataW'(mode_q) | (DataW'(zflag_q) << ErrBitPos);
        SelNum:  rd_d = num_q;
        SelDen:  rd_d = den_q;
        SelQuo:  rd_d = quo_q;
        SelRem:  rd_d = rem_q;
        default: rd_d = '0;
      endcase
    end
    wide = (mode_d == Mode6432) || (mode_d == Mode6464);
    n_op = wide ? num_d : {{32{num_d[31]}}, num_d[31:0]};
    d_op = (mode_d == Mode6464) ? den_d : {{32{den_d[31]}}, den_d[31:0]};
    spec_d = 1'b1;
    if (wide && n_op == {1'b1, 63'd0} && d_op == AllOnes) begin
      sq_d = {1'b1, 63'd0};
      sr_d = '0;
    end else if (!wide && n_op == 64'hFFFF_FFFF_8000_0000 && d_op == AllOnes) begin
      sq_d = 64'h0000_0000_8000_0000;
      sr_d = '0;
    end else if (d_op == '0) begin
      if (wide) sq_d = n_op[63] ? 64'd1 : AllOnes;
      else      sq_d = n_op[63] ? NegZeroDiv32 : Low32Mask;
      sr_d = n_op;
    end else begin
      spec_d = 1'b0;
      sq_d   = '0;
      sr_d   = '0;
    end
    rsh   = {dr_q[DataW-2:0], dq_q[DataW-1]};
    trial = {1'b0, rsh} - {1'b0, dd_q};
  end

  assign sts_o.last_step = (cnt_q == CntW'(DataW - 1));
  assign read_data_o     = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      zflag_q <= 1'b0;
      num_q   <= '0;
      den_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      rd_q    <= '0;
      spec_q  <= 1'b0;
      sq_q    <= '0;
      sr_q    <= '0;
      nneg_q  <= 1'b0;
      qneg_q  <= 1'b0;
      dq_q    <= '0;
      dd_q    <= '0;
      dr_q    <= '0;
    end else if (cmd_i.load) begin
      mode_q <= mode_d;
      num_q  <= num_d;
      den_q  <= den_d;
      rd_q   <= rd_d;
      spec_q <= spec_d;
      sq_q   <= sq_d;
      sr_q   <= sr_d;
      nneg_q <= n_op[63];
      qneg_q <= n_op[63] ^ d_op[63];
      dq_q   <= n_op[63] ? -n_op : n_op;
      dd_q   <= d_op[63] ? -d_op : d_op;
      dr_q   <= '0;
      cnt_q  <= '0;
      if (operation_i) zflag_q <= (den_d == '0);
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CntW'(1);
      if (!trial[DataW]) begin
        dr_q <= trial[DataW-1:0];
        dq_q <= {dq_q[DataW-2:0], 1'b1};
      end else begin
        dr_q <= rsh;
        dq_q <= {dq_q[DataW-2:0], 1'b0};
      end
    end else if (cmd_i.finish) begin
      quo_q <= spec_q ? sq_q : (qneg_q ? -dq_q : dq_q);
      rem_q <= spec_q ? sr_q : (nneg_q ? -dr_q : dr_q);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !cmd_i.load && !cmd_i.finish)
    else $error("step overlaps other command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !spec_q |=> dr_q < dd_q)
    else $error("partial remainder not below divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && operation_i |=> rd_q == '0)
    else $error("write returns nonzero data");
endmodule
`default_nettype wire

@@ hw/rtl/sdr_ctrl.sv @@
// Controller sequencing load, 64 divide steps and fix-up.
// Depends on sdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdr_ctrl import sdr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     operation_i,
  input  wire sdr_sts_t sts_i,
  output sdr_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  typedef enum logic [1:0] {Idle, Step, Fix} state_e;
  state_e state_q;
  logic   busy_q, done_q;

  always_comb begin
    cmd_o.load   = start_i && !busy_q;
    cmd_o.step   = (state_q == Step);
    cmd_o.finish = (state_q == Fix);
  end
  assign busy_o = busy_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        Idle: begin
          if (start_i && !busy_q) begin
            if (operation_i) begin
              state_q <= Step;
              busy_q  <= 1'b1;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        Step: begin
          if (sts_i.last_step) state_q <= Fix;
        end
        Fix: begin
          state_q <= Idle;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != Idle) |-> busy_q)
    else $error("busy low while dividing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Fix) |=> done_q && (state_q == Idle))
    else $error("fix-up did not complete request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Step) |-> !done_q)
    else $error("completion while dividing");
endmodule
`default_nettype wire
